FILE: sv/jpfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpfm_pkg
// Shared types, field widths and codes of the jet parton flavour matcher.
// ----------------------------------------------------------------------------
package jpfm_pkg;

   localparam int ETA_W      = 14;
   localparam int PHI_W      = 13;
   localparam int PT_W       = 16;
   localparam int PDG_W      = 16;
   localparam int STATUS_W   = 8;
   localparam int IDX_W      = 10;
   localparam int MODE_W     = 2;
   localparam int LIMIT_W    = 24;
   localparam int CLASS_W    = 3;
   localparam int PCOUNT_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int DETA_W  = ETA_W + 1;
   localparam int SQ_ETA_W = 2 * DETA_W - 1;
   localparam int SQ_PHI_W = 2 * PHI_W - 1;
   localparam int D2_W     = SQ_ETA_W + 1;

   localparam int MAX_PARTICLES_DEF = 1024;
   localparam int QUEUE_DEPTH       = 4;

   // command codes
   localparam logic CMD_JET  = 1'b0;
   localparam logic CMD_PART = 1'b1;

   // match modes
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALGO = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PHYS = 2'd2;

   // result classes
   localparam logic [CLASS_W-1:0] CLASS_NONE  = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_B     = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_C     = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_LIGHT = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_PHYS  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_R_SQ     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HARD_STATUS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_UNMATCHED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_MATCHED   = 3'd4;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 24'd152881;
   localparam logic [STATUS_W-1:0] STATUS_RESET = 8'd3;

   // parton id constants
   localparam logic signed [PDG_W-1:0] PDG_GLUON = 16'sd21;
   localparam logic signed [PDG_W-1:0] PDG_B     = 16'sd5;
   localparam logic signed [PDG_W-1:0] PDG_C     = 16'sd4;
   localparam logic signed [PDG_W-1:0] PDG_LOW   = 16'sd1;

   typedef enum logic [1:0] {
      KIND_LIGHT = 2'b00,
      KIND_B     = 2'b01,
      KIND_C     = 2'b10
   } kind_type;

   // classified particle travelling from front to back
   typedef struct packed {
      logic             cmd;
      logic             last;
      logic             hit;
      logic             hard;
      kind_type         kind;
      logic [PT_W-1:0]  pt;
      logic [PDG_W-1:0] pdg;
   } rec_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [PDG_W-1:0] pdg;
      logic [PT_W-1:0]  pt;
   } cand_type;

endpackage

FILE: sv/jpfm_ram_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpfm_ram_queue
// Small first-in first-out queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module jpfm_ram_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: sv/jpfm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpfm_front
// Accepts items, holds the jet direction and classifies each particle
// (parton type, status, delta-R cone test) over two pipeline stages.
// ----------------------------------------------------------------------------
module jpfm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic signed [jpfm_pkg::ETA_W-1:0]    req_eta,
   input  logic signed [jpfm_pkg::PHI_W-1:0]    req_phi,
   input  logic [jpfm_pkg::PT_W-1:0]            req_pt,
   input  logic signed [jpfm_pkg::PDG_W-1:0]    req_pdg_id,
   input  logic [jpfm_pkg::STATUS_W-1:0]        req_status,
   input  logic                                 req_last,
   input  logic [jpfm_pkg::LIMIT_W-1:0]         delta_r_sq_limit,
   input  logic [jpfm_pkg::STATUS_W-1:0]        hard_status,
   input  logic                                 q_full,
   output logic                                 q_push,
   output jpfm_pkg::rec_type                    q_rec
);

   logic                                 advance;
   logic                                 accept;
   logic signed [jpfm_pkg::ETA_W-1:0]    jet_eta_ff;
   logic signed [jpfm_pkg::PHI_W-1:0]    jet_phi_ff;

   logic signed [jpfm_pkg::DETA_W-1:0]   deta_in;
   logic signed [jpfm_pkg::PHI_W-1:0]    dphi_in;
   logic                                 qual_in;
   jpfm_pkg::kind_type                   kind_in;

   logic                                 s1_valid_ff;
   jpfm_pkg::rec_type                    s1_rec_ff;
   logic                                 s1_qual_ff;
   logic signed [jpfm_pkg::DETA_W-1:0]   s1_deta_ff;
   logic signed [jpfm_pkg::PHI_W-1:0]    s1_dphi_ff;

   logic signed [2*jpfm_pkg::DETA_W-1:0] sq_eta_full;
   logic signed [2*jpfm_pkg::PHI_W-1:0]  sq_phi_full;

   logic                                 s2_valid_ff;
   jpfm_pkg::rec_type                    s2_rec_ff;
   logic                                 s2_qual_ff;
   logic [jpfm_pkg::SQ_ETA_W-1:0]        s2_sq_eta_ff;
   logic [jpfm_pkg::SQ_PHI_W-1:0]        s2_sq_phi_ff;

   logic [jpfm_pkg::D2_W-1:0]            d2;

   // pipeline moves as one unless the last stage cannot enter the queue
   assign advance   = !(s2_valid_ff && q_full);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign deta_in = jpfm_pkg::DETA_W'(req_eta) - jpfm_pkg::DETA_W'(jet_eta_ff);
   // phi difference wraps in its own width
   assign dphi_in = req_phi - jet_phi_ff;

   always_comb begin
      qual_in = ((req_pdg_id >= jpfm_pkg::PDG_LOW) && (req_pdg_id <= jpfm_pkg::PDG_B))
             || ((req_pdg_id <= -jpfm_pkg::PDG_LOW) && (req_pdg_id >= -jpfm_pkg::PDG_B))
             || (req_pdg_id == jpfm_pkg::PDG_GLUON);
      if ((req_pdg_id == jpfm_pkg::PDG_B) || (req_pdg_id == -jpfm_pkg::PDG_B)) begin
         kind_in = jpfm_pkg::KIND_B;
      end else if ((req_pdg_id == jpfm_pkg::PDG_C) || (req_pdg_id == -jpfm_pkg::PDG_C)) begin
         kind_in = jpfm_pkg::KIND_C;
      end else begin
         kind_in = jpfm_pkg::KIND_LIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jet_eta_ff  <= '0;
         jet_phi_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept && (req_cmd == jpfm_pkg::CMD_JET)) begin
            jet_eta_ff <= req_eta;
            jet_phi_ff <= req_phi;
         end
         if (advance) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign sq_eta_full = s1_deta_ff * s1_deta_ff;
   assign sq_phi_full = s1_dphi_ff * s1_dphi_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rec_ff.cmd  <= req_cmd;
         s1_rec_ff.last <= req_last;
         s1_rec_ff.hit  <= 1'b0;
         s1_rec_ff.hard <= (req_status == hard_status);
         s1_rec_ff.kind <= kind_in;
         s1_rec_ff.pt   <= req_pt;
         s1_rec_ff.pdg  <= req_pdg_id;
         s1_qual_ff     <= qual_in;
         s1_deta_ff     <= deta_in;
         s1_dphi_ff     <= dphi_in;

         s2_rec_ff      <= s1_rec_ff;
         s2_qual_ff     <= s1_qual_ff;
         s2_sq_eta_ff   <= sq_eta_full[jpfm_pkg::SQ_ETA_W-1:0];
         s2_sq_phi_ff   <= sq_phi_full[jpfm_pkg::SQ_PHI_W-1:0];
      end
   end

   assign d2 = jpfm_pkg::D2_W'(s2_sq_eta_ff) + jpfm_pkg::D2_W'(s2_sq_phi_ff);

   always_comb begin
      q_rec     = s2_rec_ff;
      q_rec.hit = s2_qual_ff && (d2 < jpfm_pkg::D2_W'(delta_r_sq_limit));
   end

   assign q_push = s2_valid_ff && !q_full;

endmodule

FILE: sv/jpfm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpfm_back
// Takes classified particles from the queue, keeps the per-jet candidates
// and registers one result on the last item of each jet.
// ----------------------------------------------------------------------------
module jpfm_back #(
   parameter int MAX_PARTICLES = jpfm_pkg::MAX_PARTICLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_not_empty,
   input  jpfm_pkg::rec_type                    q_rec,
   output logic                                 q_pop,
   input  logic [jpfm_pkg::MODE_W-1:0]          match_mode,
   input  logic                                 limit_zero,
   input  logic                                 drop_unmatched,
   input  logic                                 drop_matched,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_matched,
   output logic [jpfm_pkg::IDX_W-1:0]           rsp_match_index,
   output logic signed [jpfm_pkg::PDG_W-1:0]    rsp_match_pdg_id,
   output logic [jpfm_pkg::PT_W-1:0]            rsp_match_pt,
   output logic [jpfm_pkg::CLASS_W-1:0]         rsp_match_class,
   output logic                                 rsp_drop_jet
);

   localparam int IDX_MAX = (1 << jpfm_pkg::IDX_W) - 1;
   localparam int CAP     = (MAX_PARTICLES - 1 > IDX_MAX) ? IDX_MAX : MAX_PARTICLES - 1;
   localparam logic [jpfm_pkg::IDX_W-1:0] CAP_IDX = jpfm_pkg::IDX_W'(CAP);

   logic [jpfm_pkg::IDX_W-1:0]    counter_ff, counter_in;
   logic                          algo_seen_ff, algo_seen_in;
   logic [jpfm_pkg::PCOUNT_W-1:0] phys_count_ff, phys_count_in;
   jpfm_pkg::cand_type            best_b_ff, best_b_in;
   jpfm_pkg::cand_type            best_c_ff, best_c_in;
   jpfm_pkg::cand_type            best_light_ff, best_light_in;
   jpfm_pkg::cand_type            phys_pick_ff, phys_pick_in;
   jpfm_pkg::cand_type            offer_cand;
   jpfm_pkg::cand_type            pick;
   logic [jpfm_pkg::CLASS_W-1:0]  pick_class;
   logic                          drop;

   logic                          rsp_valid_ff;
   logic                          matched_ff;
   logic [jpfm_pkg::IDX_W-1:0]    idx_ff;
   logic [jpfm_pkg::PDG_W-1:0]    pdg_ff;
   logic [jpfm_pkg::PT_W-1:0]     pt_ff;
   logic [jpfm_pkg::CLASS_W-1:0]  class_ff;
   logic                          drop_ff;

   function automatic jpfm_pkg::cand_type offer(jpfm_pkg::cand_type c,
                                                jpfm_pkg::cand_type n);
      jpfm_pkg::cand_type r;
      r = c;
      if (!c.valid || (n.pt > c.pt)) begin
         r = n;
      end
      return r;
   endfunction

   // results wait in the output register; only a last item's pop is blocked, and only by a held result that is stalled
   assign q_pop = q_not_empty && (!q_rec.last || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      counter_in    = counter_ff;
      algo_seen_in  = algo_seen_ff;
      phys_count_in = phys_count_ff;
      best_b_in     = best_b_ff;
      best_c_in     = best_c_ff;
      best_light_in = best_light_ff;
      phys_pick_in  = phys_pick_ff;

      offer_cand.valid = 1'b1;
      offer_cand.idx   = counter_ff;
      offer_cand.pdg   = q_rec.pdg;
      offer_cand.pt    = q_rec.pt;

      if (q_rec.cmd == jpfm_pkg::CMD_JET) begin
         counter_in    = '0;
         algo_seen_in  = 1'b0;
         phys_count_in = '0;
         best_b_in     = '0;
         best_c_in     = '0;
         best_light_in = '0;
         phys_pick_in  = '0;
      end else begin
         if (counter_ff < CAP_IDX) begin
            counter_in = counter_ff + 1'b1;
         end
         if (q_rec.hit) begin
            if (!q_rec.hard) begin
               algo_seen_in = 1'b1;
               unique case (q_rec.kind)
                  jpfm_pkg::KIND_B: best_b_in = offer(best_b_ff, offer_cand);
                  jpfm_pkg::KIND_C: best_c_in = offer(best_c_ff, offer_cand);
                  default:          best_light_in = offer(best_light_ff, offer_cand);
               endcase
            end else begin
               if (phys_count_ff != '1) begin
                  phys_count_in = phys_count_ff + 1'b1;
               end
               phys_pick_in = offer_cand;
            end
         end
      end
   end

   always_comb begin
      pick       = '0;
      pick_class = jpfm_pkg::CLASS_NONE;
      if ((match_mode == jpfm_pkg::MODE_ALGO) && algo_seen_in) begin
         if (best_b_in.valid) begin
            pick       = best_b_in;
            pick_class = jpfm_pkg::CLASS_B;
         end else if (best_c_in.valid) begin
            pick       = best_c_in;
            pick_class = jpfm_pkg::CLASS_C;
         end else if (best_light_in.valid) begin
            pick       = best_light_in;
            pick_class = jpfm_pkg::CLASS_LIGHT;
         end
      end else if ((match_mode == jpfm_pkg::MODE_PHYS) && (phys_count_in == 2'd1)) begin
         pick       = phys_pick_in;
         pick.valid = 1'b1;
         pick_class = jpfm_pkg::CLASS_PHYS;
      end
      drop = !limit_zero && (pick.valid ? drop_matched : drop_unmatched);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff    <= '0;
         algo_seen_ff  <= 1'b0;
         phys_count_ff <= '0;
         best_b_ff     <= '0;
         best_c_ff     <= '0;
         best_light_ff <= '0;
         phys_pick_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            counter_ff    <= counter_in;
            algo_seen_ff  <= algo_seen_in;
            phys_count_ff <= phys_count_in;
            best_b_ff     <= best_b_in;
            best_c_ff     <= best_c_in;
            best_light_ff <= best_light_in;
            phys_pick_ff  <= phys_pick_in;
         end
         if (q_pop && q_rec.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_rec.last) begin
         matched_ff <= pick.valid;
         idx_ff     <= pick.idx;
         pdg_ff     <= pick.pdg;
         pt_ff      <= pick.pt;
         class_ff   <= pick_class;
         drop_ff    <= drop;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched      = matched_ff;
   assign rsp_match_index  = idx_ff;
   assign rsp_match_pdg_id = signed'(pdg_ff);
   assign rsp_match_pt     = pt_ff;
   assign rsp_match_class  = class_ff;
   assign rsp_drop_jet     = drop_ff;

`ifndef SYNTHESIS
   a_class_matches_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (matched_ff == (class_ff != jpfm_pkg::CLASS_NONE)))
      else $error("result class disagrees with matched flag");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !matched_ff) |-> ((idx_ff == '0) && (pdg_ff == '0) && (pt_ff == '0)))
      else $error("unmatched result carries nonzero payload");

   a_best_needs_seen: assert property (@(posedge clock) disable iff (reset)
      (best_b_ff.valid || best_c_ff.valid || best_light_ff.valid) |-> algo_seen_ff)
      else $error("candidate kept without algorithmic flag");

   a_jet_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_rec.cmd == jpfm_pkg::CMD_JET))
      |=> ((counter_ff == '0) && (phys_count_ff == '0) && !algo_seen_ff))
      else $error("jet item did not clear running state");
`endif

endmodule

FILE: sv/jet_parton_flavour_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_parton_flavour_matcher_top
// Delta-R jet parton flavour matcher with algorithmic and physics modes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries jet items (cmd 0) and particle items (cmd 1); an item is
//   taken on a clock edge with req_valid high and req_stall low. Every item
//   with last set yields one transaction on rsp_*, taken with rsp_valid high
//   and rsp_stall low. Registers are written on csr_* (index, data) with
//   csr_valid and csr_ready high; the user must write them only while the
//   block is idle, which the block itself does not enforce. A front pipeline
//   (difference, squares, cone compare) feeds a four-entry queue; the back
//   end updates the per-jet candidates one record a cycle unless a stalled
//   result blocks a last item. Throughput: one item per cycle when nothing
//   stalls, set by the candidate update in the back end.
//   When rsp_stall holds a result, the back end keeps taking particles up to
//   the next last item, the queue fills, and then req_stall rises.
//   Synchronous reset clears the pipeline, queue, jet direction, running
//   state and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module jet_parton_flavour_matcher_top #(
   parameter int MAX_PARTICLES = jpfm_pkg::MAX_PARTICLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic signed [jpfm_pkg::ETA_W-1:0]    req_eta,
   input  logic signed [jpfm_pkg::PHI_W-1:0]    req_phi,
   input  logic [jpfm_pkg::PT_W-1:0]            req_pt,
   input  logic signed [jpfm_pkg::PDG_W-1:0]    req_pdg_id,
   input  logic [jpfm_pkg::STATUS_W-1:0]        req_status,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_matched,
   output logic [jpfm_pkg::IDX_W-1:0]           rsp_match_index,
   output logic signed [jpfm_pkg::PDG_W-1:0]    rsp_match_pdg_id,
   output logic [jpfm_pkg::PT_W-1:0]            rsp_match_pt,
   output logic [jpfm_pkg::CLASS_W-1:0]         rsp_match_class,
   output logic                                 rsp_drop_jet,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jpfm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jpfm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int REC_W = $bits(jpfm_pkg::rec_type);

   logic [jpfm_pkg::MODE_W-1:0]   match_mode_ff;
   logic [jpfm_pkg::LIMIT_W-1:0]  limit_ff;
   logic [jpfm_pkg::STATUS_W-1:0] hard_status_ff;
   logic                          drop_unmatched_ff;
   logic                          drop_matched_ff;

   logic                          q_push;
   logic                          q_pop;
   logic                          q_full;
   logic                          q_not_empty;
   jpfm_pkg::rec_type             push_rec;
   jpfm_pkg::rec_type             pop_rec;
   logic [REC_W-1:0]              q_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_mode_ff     <= jpfm_pkg::MODE_NONE;
         limit_ff          <= jpfm_pkg::LIMIT_RESET;
         hard_status_ff    <= jpfm_pkg::STATUS_RESET;
         drop_unmatched_ff <= 1'b0;
         drop_matched_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            jpfm_pkg::CSR_MATCH_MODE:
               match_mode_ff <= csr_wdata[jpfm_pkg::MODE_W-1:0];
            jpfm_pkg::CSR_DELTA_R_SQ:
               limit_ff <= csr_wdata[jpfm_pkg::LIMIT_W-1:0];
            jpfm_pkg::CSR_HARD_STATUS:
               hard_status_ff <= csr_wdata[jpfm_pkg::STATUS_W-1:0];
            jpfm_pkg::CSR_DROP_UNMATCHED:
               drop_unmatched_ff <= csr_wdata[0];
            jpfm_pkg::CSR_DROP_MATCHED:
               drop_matched_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   jpfm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_eta          (req_eta),
      .req_phi          (req_phi),
      .req_pt           (req_pt),
      .req_pdg_id       (req_pdg_id),
      .req_status       (req_status),
      .req_last         (req_last),
      .delta_r_sq_limit (limit_ff),
      .hard_status      (hard_status_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_rec            (push_rec)
   );

   jpfm_ram_queue #(
      .WIDTH (REC_W),
      .DEPTH (jpfm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (REC_W'(push_rec)),
      .pop       (q_pop),
      .rd_data   (q_rd_data),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   assign pop_rec = jpfm_pkg::rec_type'(q_rd_data);

   jpfm_back #(
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_rec            (pop_rec),
      .q_pop            (q_pop),
      .match_mode       (match_mode_ff),
      .limit_zero       (limit_ff == '0),
      .drop_unmatched   (drop_unmatched_ff),
      .drop_matched     (drop_matched_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .rsp_match_index  (rsp_match_index),
      .rsp_match_pdg_id (rsp_match_pdg_id),
      .rsp_match_pt     (rsp_match_pt),
      .rsp_match_class  (rsp_match_class),
      .rsp_drop_jet     (rsp_drop_jet)
   );

endmodule
